// File: hw/rtl/tunnel_texture_coord_mapper_assert.svh
// assertion macros for the tunnel texture coordinate mapper
`ifndef TUNNEL_TEXTURE_COORD_MAPPER_ASSERT_SVH
`define TUNNEL_TEXTURE_COORD_MAPPER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TTCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");
`define TTCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("assertion failed");
`else
`define TTCM_ASSERT_IMP(lbl, ante, cons)
`define TTCM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/ttcm_pkg.sv
// shared constants, types and step functions of the tunnel texture mapper
package ttcm_pkg;
  localparam int TEX_BITS      = 9;
  localparam int RAY_FRAC_BITS = 16;
  localparam int RAY_W         = RAY_FRAC_BITS + 2;
  localparam int GUARD         = 24 - RAY_FRAC_BITS;
  localparam int SUM_W         = 2 * RAY_W;
  localparam int RAD_W         = SUM_W + 2 * GUARD;
  localparam int ROOT_W        = RAD_W / 2;
  localparam int SQR_W         = ROOT_W + 3;
  localparam int CFG_W         = 16;
  localparam int IDX_W         = 2;
  localparam int PROD_W        = RAY_W + CFG_W;
  localparam int DEPTH_FRAC    = 8;
  localparam int SHIFT         = DEPTH_FRAC + GUARD;
  localparam int DM_W          = 32;
  localparam int CORDIC_STEPS  = 24;
  localparam int CRD_W         = RAY_W + GUARD + 2;
  localparam int ANG_W         = 34;
  localparam int ANG_FRAC      = 32;
  localparam int BR_W          = DEPTH_FRAC + 1;
  localparam int LQ_W          = CFG_W + DEPTH_FRAC;
  localparam int N_STAGES      = ROOT_W + DM_W + BR_W + 7;
  localparam int VD            = N_STAGES - CORDIC_STEPS - 3;

  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_FADE   = 2'd1;
  localparam logic [CFG_W-1:0] RADIUS_RST = 16'd100;
  localparam logic [CFG_W-1:0] FADE_RST   = 16'd2000;
  localparam logic [TEX_BITS-1:0] TEX_MAX = '1;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic [DM_W-1:0] LIMIT_POS = 32'h7FFF_FF00;
  localparam logic [DM_W-1:0] LIMIT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic              qbit;
  } dstep_t;

  typedef struct packed {
    logic [CFG_W-1:0] rem;
    logic             qbit;
  } bstep_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // one digit of the restoring square root
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] b);
    logic [SQR_W-1:0] r2;
    logic [SQR_W-1:0] tr;
    sqrt_st_t o;
    r2 = {s.rem[SQR_W-3:0], b};
    tr = {{(SQR_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of the depth division
  function automatic dstep_t div_step(input logic [ROOT_W-1:0] rem,
                                      input logic [ROOT_W-1:0] dvs, input logic b);
    logic [ROOT_W:0] r2;
    logic [ROOT_W:0] d;
    dstep_t o;
    r2 = {rem, b};
    d  = {1'b0, dvs};
    if (r2 >= d) begin
      r2     = r2 - d;
      o.qbit = 1'b1;
    end else begin
      o.qbit = 1'b0;
    end
    o.rem = r2[ROOT_W-1:0];
    return o;
  endfunction

  // one quotient bit of the brightness division
  function automatic bstep_t br_step(input logic [CFG_W-1:0] rem,
                                     input logic [CFG_W-1:0] dvs, input logic b);
    logic [CFG_W:0] r2;
    logic [CFG_W:0] d;
    bstep_t o;
    r2 = {rem, b};
    d  = {1'b0, dvs};
    if (r2 >= d) begin
      r2     = r2 - d;
      o.qbit = 1'b1;
    end else begin
      o.qbit = 1'b0;
    end
    o.rem = r2[CFG_W-1:0];
    return o;
  endfunction
endpackage

// File: hw/rtl/tunnel_texture_coord_mapper.sv
// tunnel texture coordinate mapper: ray direction in, texture coordinates out
//
// A ray (ray_x, ray_y, ray_z, signed Q1.16) is taken at each clock edge where
// start is high; busy is always low, so one ray can be issued every cycle.
// Each request gives one result: done is high for one cycle with hit,
// tex_u, tex_v and brightness. The pipeline holds 2 input and square
// stages, 26 square-root digit stages, a radius multiply, an overflow
// check, 32 depth-division stages, a clamp, a brightness setup stage, 9
// brightness-division stages and the output register. The angle runs
// beside it in 24 CORDIC stages and waits in a delay line. Throughput is
// one ray per cycle. The receiver cannot stall; results are shown for
// exactly one cycle. radius (index 0) and fade_distance (index 1) are
// written on the cfg channel (cfg_ready always high); the user must write
// them only while no request is in flight, which the block does not
// enforce. Other indexes are ignored. Reset clears all valid bits and loads
// radius 100 and fade distance 2000; requests in flight at reset are dropped.
`include "tunnel_texture_coord_mapper_assert.svh"
module tunnel_texture_coord_mapper
  import ttcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [RAY_W-1:0] ray_x,
  input  logic signed [RAY_W-1:0] ray_y,
  input  logic signed [RAY_W-1:0] ray_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic                    hit,
  output logic [TEX_BITS-1:0]     tex_u,
  output logic [TEX_BITS-1:0]     tex_v,
  output logic [BR_W-1:0]         brightness
);

  logic [CFG_W-1:0] radius;
  logic [CFG_W-1:0] fade_distance;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= RADIUS_RST;
      fade_distance <= FADE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_RADIUS) begin
        radius <= cfg_data;
      end else if (cfg_index == REG_FADE) begin
        fade_distance <= cfg_data;
      end
    end
  end

  // input stage: magnitudes
  logic             a_vld;
  logic [RAY_W-1:0] a_ax, a_ay, a_az;
  logic             a_zneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_ax   <= ray_x[RAY_W-1] ? RAY_W'(-ray_x) : RAY_W'(ray_x);
    a_ay   <= ray_y[RAY_W-1] ? RAY_W'(-ray_y) : RAY_W'(ray_y);
    a_az   <= ray_z[RAY_W-1] ? RAY_W'(-ray_z) : RAY_W'(ray_z);
    a_zneg <= ray_z[RAY_W-1];
  end

  // square-root pipeline, element 0 holds the squared length
  logic             sq_vld  [0:ROOT_W];
  logic [SUM_W-1:0] sq_sum  [0:ROOT_W];
  logic [RAY_W-1:0] sq_az   [0:ROOT_W];
  logic             sq_zneg [0:ROOT_W];
  sqrt_st_t         sq_st   [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_sum[0]  <= SUM_W'(a_ax) * SUM_W'(a_ax) + SUM_W'(a_ay) * SUM_W'(a_ay);
    sq_az[0]   <= a_az;
    sq_zneg[0] <= a_zneg;
    sq_st[0]   <= '0;
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    logic [RAD_W-1:0] rad;
    assign rad = {sq_sum[g], {(2*GUARD){1'b0}}};
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[g+1] <= 1'b0;
      end else begin
        sq_vld[g+1] <= sq_vld[g];
      end
    end
    always_ff @(posedge clk) begin
      sq_st[g+1]   <= sqrt_step(sq_st[g], rad[RAD_W-1-2*g -: 2]);
      sq_sum[g+1]  <= sq_sum[g];
      sq_az[g+1]   <= sq_az[g];
      sq_zneg[g+1] <= sq_zneg[g];
    end
  end

  // radius multiply
  logic              m_vld;
  logic [PROD_W-1:0] m_p;
  logic [ROOT_W-1:0] m_len;
  logic              m_zneg, m_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    m_p    <= PROD_W'(sq_az[ROOT_W]) * PROD_W'(radius);
    m_len  <= sq_st[ROOT_W].root;
    m_zneg <= sq_zneg[ROOT_W];
    m_nz   <= (sq_sum[ROOT_W] != '0);
  end

  // depth division, element 0 holds the overflow check and top remainder
  logic              dv_vld  [0:DM_W];
  logic [ROOT_W-1:0] dv_rem  [0:DM_W];
  logic [DM_W-1:0]   dv_q    [0:DM_W];
  logic [ROOT_W-1:0] dv_len  [0:DM_W];
  logic [SHIFT-1:0]  dv_plo  [0:DM_W];
  logic              dv_ovf  [0:DM_W];
  logic              dv_zneg [0:DM_W];
  logic              dv_nz   [0:DM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    // quotient would not fit in DM_W bits
    dv_ovf[0]  <= ({{(ROOT_W+SHIFT-PROD_W){1'b0}}, m_p} >= {m_len, {SHIFT{1'b0}}});
    dv_rem[0]  <= ROOT_W'(m_p[PROD_W-1:SHIFT]);
    dv_q[0]    <= '0;
    dv_len[0]  <= m_len;
    dv_plo[0]  <= m_p[SHIFT-1:0];
    dv_zneg[0] <= m_zneg;
    dv_nz[0]   <= m_nz;
  end

  for (genvar g = 0; g < DM_W; g++) begin : g_div
    localparam int J = DM_W - 1 - g;
    logic   dbit;
    dstep_t st;
    if (J >= SHIFT) begin : g_pbit
      assign dbit = dv_plo[g][J-SHIFT];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end
    assign st = div_step(dv_rem[g], dv_len[g], dbit);
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[g+1] <= 1'b0;
      end else begin
        dv_vld[g+1] <= dv_vld[g];
      end
    end
    always_ff @(posedge clk) begin
      dv_rem[g+1]  <= st.rem;
      dv_q[g+1]    <= {dv_q[g][DM_W-2:0], st.qbit};
      dv_len[g+1]  <= dv_len[g];
      dv_plo[g+1]  <= dv_plo[g];
      dv_ovf[g+1]  <= dv_ovf[g];
      dv_zneg[g+1] <= dv_zneg[g];
      dv_nz[g+1]   <= dv_nz[g];
    end
  end

  // clamp to the signed 24-bit depth range
  logic            c_vld;
  logic [DM_W-1:0] c_dm;
  logic            c_nz;
  logic [DM_W-1:0] c_limit;

  assign c_limit = dv_zneg[DM_W] ? LIMIT_NEG : LIMIT_POS;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= dv_vld[DM_W];
    end
  end

  always_ff @(posedge clk) begin
    c_dm <= (dv_ovf[DM_W] || dv_q[DM_W] > c_limit) ? c_limit : dv_q[DM_W];
    c_nz <= dv_nz[DM_W];
  end

  // brightness division, element 0 holds (fade*256 - depth) split up
  logic                br_vld  [0:BR_W];
  logic [CFG_W-1:0]    br_rem  [0:BR_W];
  logic [BR_W-1:0]     br_q    [0:BR_W];
  logic [BR_W-1:0]     br_nlo  [0:BR_W];
  logic                br_zero [0:BR_W];
  logic                br_nz   [0:BR_W];
  logic [TEX_BITS-1:0] br_u    [0:BR_W];
  logic [LQ_W-1:0]     lq, nfade;

  assign lq    = {fade_distance, {DEPTH_FRAC{1'b0}}};
  assign nfade = lq - c_dm[LQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      br_vld[0] <= 1'b0;
    end else begin
      br_vld[0] <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    br_zero[0] <= (fade_distance == '0) || (c_dm >= DM_W'(lq));
    br_rem[0]  <= CFG_W'(nfade[LQ_W-1:BR_W]);
    br_nlo[0]  <= nfade[BR_W-1:0];
    br_q[0]    <= '0;
    br_nz[0]   <= c_nz;
    br_u[0]    <= c_dm[DEPTH_FRAC +: TEX_BITS];
  end

  for (genvar g = 0; g < BR_W; g++) begin : g_br
    bstep_t st;
    assign st = br_step(br_rem[g], fade_distance, br_nlo[g][BR_W-1-g]);
    always_ff @(posedge clk) begin
      if (rst) begin
        br_vld[g+1] <= 1'b0;
      end else begin
        br_vld[g+1] <= br_vld[g];
      end
    end
    always_ff @(posedge clk) begin
      br_rem[g+1]  <= st.rem;
      br_q[g+1]    <= {br_q[g][BR_W-2:0], st.qbit};
      br_nlo[g+1]  <= br_nlo[g];
      br_zero[g+1] <= br_zero[g];
      br_nz[g+1]   <= br_nz[g];
      br_u[g+1]    <= br_u[g];
    end
  end

  // cordic angle path, element 0 after the quarter-turn pre-rotation
  logic signed [CRD_W-1:0] cr_x [0:CORDIC_STEPS];
  logic signed [CRD_W-1:0] cr_y [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] cr_a [0:CORDIC_STEPS];
  logic signed [CRD_W-1:0] in_cx, in_cy;

  assign in_cx = {{(CRD_W-RAY_W-GUARD){ray_y[RAY_W-1]}}, ray_y, {GUARD{1'b0}}};
  assign in_cy = {{(CRD_W-RAY_W-GUARD){ray_x[RAY_W-1]}}, ray_x, {GUARD{1'b0}}};

  always_ff @(posedge clk) begin
    if (in_cx < 0) begin
      if (in_cy >= 0) begin
        cr_x[0] <= in_cy;
        cr_y[0] <= -in_cx;
        cr_a[0] <= QUARTER_TURN;
      end else begin
        cr_x[0] <= -in_cy;
        cr_y[0] <= in_cx;
        cr_a[0] <= -QUARTER_TURN;
      end
    end else begin
      cr_x[0] <= in_cx;
      cr_y[0] <= in_cy;
      cr_a[0] <= '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    logic signed [CRD_W-1:0] dx, dy;
    assign dx = cr_y[g] >>> g;
    assign dy = cr_x[g] >>> g;
    always_ff @(posedge clk) begin
      if (cr_y[g] >= 0) begin
        cr_x[g+1] <= cr_x[g] + dx;
        cr_y[g+1] <= cr_y[g] - dy;
        cr_a[g+1] <= cr_a[g] + atan_turn(g);
      end else begin
        cr_x[g+1] <= cr_x[g] - dx;
        cr_y[g+1] <= cr_y[g] + dy;
        cr_a[g+1] <= cr_a[g] - atan_turn(g);
      end
    end
  end

  // angle scaled by TEX_MAX per turn, truncated toward zero
  logic [ANG_W-1:0]          amag;
  logic [ANG_W+TEX_BITS-1:0] ascaled;
  logic [TEX_BITS-1:0]       kcode;
  logic [TEX_BITS-1:0]       v_k;
  logic [TEX_BITS-1:0]       v_dly [0:VD-1];

  assign amag    = cr_a[CORDIC_STEPS][ANG_W-1] ? ANG_W'(-cr_a[CORDIC_STEPS])
                                               : ANG_W'(cr_a[CORDIC_STEPS]);
  assign ascaled = {amag, {TEX_BITS{1'b0}}} - (ANG_W+TEX_BITS)'(amag);
  assign kcode   = ascaled[ANG_FRAC +: TEX_BITS];

  always_ff @(posedge clk) begin
    if (cr_a[CORDIC_STEPS][ANG_W-1] && kcode != '0) begin
      v_k <= TEX_MAX - kcode;
    end else begin
      v_k <= kcode;
    end
    v_dly[0] <= v_k;
  end

  for (genvar g = 1; g < VD; g++) begin : g_vdly
    always_ff @(posedge clk) begin
      v_dly[g] <= v_dly[g-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= br_vld[BR_W];
    end
  end

  always_ff @(posedge clk) begin
    hit        <= br_nz[BR_W];
    tex_u      <= br_nz[BR_W] ? br_u[BR_W] : '0;
    tex_v      <= br_nz[BR_W] ? v_dly[VD-1] : '0;
    brightness <= (br_nz[BR_W] && !br_zero[BR_W]) ? br_q[BR_W] : '0;
  end

  `TTCM_ASSERT_IMP(a_latency, start && !busy, ##(N_STAGES) done)
  `TTCM_ASSERT_IMP(a_miss_zero, done && !hit,
                   (tex_u == '0 && tex_v == '0 && brightness == '0))
  `TTCM_ASSERT_IMP(a_bright_max, done, (brightness <= BR_W'(1 << DEPTH_FRAC)))
  `TTCM_ASSERT_NXT(a_radius_wr, cfg_valid && cfg_ready && cfg_index == REG_RADIUS,
                   (radius == $past(cfg_data)))

endmodule

// File: test/tb_tunnel_texture_coord_mapper.sv
// testbench for the tunnel texture coordinate mapper: directed, config and random rays
module tb_tunnel_texture_coord_mapper;
  import ttcm_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 90;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint ATAN_TBL [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  typedef struct packed {
    logic                hit;
    logic [TEX_BITS-1:0] tex_u;
    logic [TEX_BITS-1:0] tex_v;
    logic [BR_W-1:0]     brightness;
  } texel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [RAY_W-1:0] ray_x = '0;
  logic signed [RAY_W-1:0] ray_y = '0;
  logic signed [RAY_W-1:0] ray_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done, hit;
  logic [TEX_BITS-1:0] tex_u, tex_v;
  logic [BR_W-1:0] brightness;

  logic [CFG_W-1:0] radius_model = RADIUS_RST;
  logic [CFG_W-1:0] fade_model = FADE_RST;
  texel_t texel_q[$];
  int mismatches = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  tunnel_texture_coord_mapper u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ray_x(ray_x), .ray_y(ray_y), .ray_z(ray_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .hit(hit), .tex_u(tex_u), .tex_v(tex_v),
    .brightness(brightness)
  );

  function automatic texel_t map_ray(input logic signed [RAY_W-1:0] rx,
                                     input logic signed [RAY_W-1:0] ry,
                                     input logic signed [RAY_W-1:0] rz);
    texel_t r;
    longint x, y, z, cx, cy, ang, t, dx, dy;
    longint unsigned ax, ay, az, n, root, rbit, dm, lim, k, amag, lq;
    x = rx; y = ry; z = rz;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    r = '0;
    if (ax * ax + ay * ay == 0) return r;
    r.hit = 1'b1;
    // integer square root with guard bits
    n = (ax * ax + ay * ay) << (2 * GUARD);
    root = 0;
    rbit = 64'd1 << 62;
    while (rbit > n) rbit >>= 2;
    while (rbit != 0) begin
      if (n >= root + rbit) begin
        n -= root + rbit;
        root = (root >> 1) + rbit;
      end else begin
        root >>= 1;
      end
      rbit >>= 2;
    end
    dm = ((az * radius_model) << (DEPTH_FRAC + GUARD)) / root;
    lim = (z < 0) ? (64'd8388608 << DEPTH_FRAC) : (64'd8388607 << DEPTH_FRAC);
    if (dm > lim) dm = lim;
    r.tex_u = TEX_BITS'(dm >> DEPTH_FRAC);
    // angle by vectoring, x and y swapped
    cx = y <<< GUARD;
    cy = x <<< GUARD;
    ang = 0;
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; ang = QUARTER_TURN;
      end else begin
        t = cx; cx = -cy; cy = t; ang = -longint'(QUARTER_TURN);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += ATAN_TBL[i];
      end else begin
        cx -= dx; cy += dy; ang -= ATAN_TBL[i];
      end
    end
    amag = (ang < 0) ? -ang : ang;
    k = (amag * 511) >> 32;
    r.tex_v = TEX_BITS'((ang < 0 && k > 0) ? 511 - k : k);
    if (fade_model != 0) begin
      lq = longint'(fade_model) << DEPTH_FRAC;
      r.brightness = BR_W'((dm >= lq) ? 0 : (lq - dm) / fade_model);
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    texel_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** tunnel_texture_coord_mapper: FAILED **");
      $finish;
    end else if (!rst && done) begin
      if (texel_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = texel_q.pop_front();
        if (hit !== e.hit) report("hit", hit, e.hit);
        if (tex_u !== e.tex_u) report("tex_u", tex_u, e.tex_u);
        if (tex_v !== e.tex_v) report("tex_v", tex_v, e.tex_v);
        if (brightness !== e.brightness) report("brightness", brightness, e.brightness);
      end
    end
  end

  task automatic send_ray(input logic signed [RAY_W-1:0] x,
                          input logic signed [RAY_W-1:0] y,
                          input logic signed [RAY_W-1:0] z);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    ray_x <= x;
    ray_y <= y;
    ray_z <= z;
    do @(posedge clk); while (busy);
    texel_q.push_back(map_ray(x, y, z));
  endtask

  // hold off until every result is back, then let the pipeline empty
  task automatic drain();
    start <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_RADIUS) radius_model = val;
    else if (idx == REG_FADE) fade_model = val;
    @(posedge clk);
  endtask

  function automatic logic signed [RAY_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return RAY_W'($urandom_range(0, 15) - 8);
      1: return ($urandom_range(0, 1)) ? 18'sh1FFFF : -18'sh20000;
      default: return RAY_W'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_ray(0, 0, 0);
    send_ray(0, 0, 18'sh1FFFF);
    send_ray(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF);
    send_ray(-18'sh20000, -18'sh20000, -18'sh20000);
    send_ray(18'sh10000, 0, 18'sh10000);
    send_ray(0, 18'sh10000, 18'sh10000);
    send_ray(-18'sh10000, 0, -18'sh10000);
    send_ray(0, -18'sh10000, 18'sh08000);
    send_ray(1, 0, 18'sh1FFFF);
    send_ray(0, -1, -18'sh20000);
    send_ray(-1, 18'sh10000, 18'sh00100);
    send_ray(-1, -18'sh10000, 1);
    send_ray(18'sh1FFFF, -18'sh20000, 0);
    send_ray(-18'sh20000, 18'sh1FFFF, 18'sh00010);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_FADE, 16'd1);
    send_ray(1, 1, 18'sh1FFFF);
    send_ray(1, 0, -18'sh20000);
    send_ray(18'sh10000, 0, 1);
    drain();
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_FADE, 16'd0);
    send_ray(18'sh01234, -18'sh04321, 18'sh1FFFF);
    send_ray(5, 7, -3);
    drain();
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hFFFF);
    write_reg(REG_RADIUS, 16'd1);
    write_reg(REG_FADE, 16'hFFFF);
    send_ray(18'sh00100, 18'sh00200, 18'sh1FFFF);
    send_ray(-18'sh00100, 18'sh00020, -18'sh1FFFF);
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(REG_RADIUS, (phase == 0) ? RADIUS_RST : CFG_W'($urandom_range(0, 65535)));
      write_reg(REG_FADE, (phase == 0) ? FADE_RST : CFG_W'($urandom_range(0, 65535)));
      for (int i = 0; i < 100; i++) send_ray(rand_comp(), rand_comp(), rand_comp());
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    if (mismatches == 0) begin
      $display("** tunnel_texture_coord_mapper: PASSED **");
    end else begin
      $display("** tunnel_texture_coord_mapper: FAILED **");
    end
    $finish;
  end
endmodule
